[sv/trc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trc_pkg
// Shared types, constants and modular helpers for the three-rotor reflector
// cipher.
// ----------------------------------------------------------------------------
package trc_pkg;

  // Alphabet size and the width of one letter index.
  localparam int unsigned ALPHA_N  = 26;
  localparam int unsigned LETTER_W = $clog2(ALPHA_N);

  // Fixed widths of the interface fields.
  localparam int unsigned OP_W    = 1;
  localparam int unsigned SEL_W   = 2;
  localparam int unsigned FIELD_W = 5;
  localparam int unsigned CHAR_W  = 8;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [CHAR_W-1:0]   char_t;

  // Letter bounds, at the widths where they are compared.
  localparam logic [LETTER_W:0] ALPHA_N_E   = (LETTER_W + 1)'(ALPHA_N);
  localparam letter_t           ALPHA_LAST  = LETTER_W'(ALPHA_N - 1);
  localparam logic [FIELD_W:0]  FIELD_LIM   = (FIELD_W + 1)'(ALPHA_N);
  localparam logic [CHAR_W:0]   CHAR_LIM    = (CHAR_W + 1)'(ALPHA_N);
  localparam char_t             LETTER_BASE = 8'd65;

  // Item opcodes.
  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 1'b0,
    OP_CIPHER = 1'b1
  } op_e;

  // Load targets.
  typedef enum logic [SEL_W-1:0] {
    SEL_PLUG   = 2'd0,
    SEL_LEFT   = 2'd1,
    SEL_MIDDLE = 2'd2,
    SEL_RIGHT  = 2'd3
  } table_sel_e;

  // One table write: enable, entry index and mapped value.
  typedef struct packed {
    logic    en;
    letter_t idx;
    letter_t val;
  } tbl_wr_t;

  // Position step controls for the odometer.
  typedef struct packed {
    logic step;
  } odo_ctrl_t;

  // (x - p) mod N for x, p below N.
  function automatic letter_t sub_mod(letter_t x, letter_t p);
    logic [LETTER_W:0] t;
    if (x >= p) begin
      t = {1'b0, x} - {1'b0, p};
    end else begin
      t = {1'b0, x} + ALPHA_N_E - {1'b0, p};
    end
    return t[LETTER_W-1:0];
  endfunction

  // (x + p) mod N for x, p below N.
  function automatic letter_t add_mod(letter_t x, letter_t p);
    logic [LETTER_W:0] s;
    s = {1'b0, x} + {1'b0, p};
    if (s >= ALPHA_N_E) begin
      s = s - ALPHA_N_E;
    end
    return s[LETTER_W-1:0];
  endfunction

endpackage

[sv/trc_plugboard.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trc_plugboard
// Plugboard map, kept as two identical register copies: one serves the
// entry lookup and one the exit lookup.
// ----------------------------------------------------------------------------
module trc_plugboard (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  trc_pkg::tbl_wr_t wr_i,
  input  trc_pkg::letter_t entry_i,
  output trc_pkg::letter_t entry_o,
  input  trc_pkg::letter_t exit_i,
  output trc_pkg::letter_t exit_o
);

  trc_pkg::letter_t entry_map_q [trc_pkg::ALPHA_N];
  trc_pkg::letter_t exit_map_q  [trc_pkg::ALPHA_N];

  // A pair load writes both directions; other entries keep their value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < trc_pkg::ALPHA_N; i++) begin
        entry_map_q[i] <= trc_pkg::LETTER_W'(i);
        exit_map_q[i]  <= trc_pkg::LETTER_W'(i);
      end
    end else if (wr_i.en) begin
      for (int i = 0; i < trc_pkg::ALPHA_N; i++) begin
        if (wr_i.idx == trc_pkg::LETTER_W'(i)) begin
          entry_map_q[i] <= wr_i.val;
          exit_map_q[i]  <= wr_i.val;
        end else if (wr_i.val == trc_pkg::LETTER_W'(i)) begin
          entry_map_q[i] <= wr_i.idx;
          exit_map_q[i]  <= wr_i.idx;
        end
      end
    end
  end

  // Lookups.
  assign entry_o = entry_map_q[entry_i];
  assign exit_o  = exit_map_q[exit_i];

endmodule

[sv/trc_rotor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trc_rotor
// One rotor: forward and inverse wiring tables with the position offset
// applied on both the inbound and the return path.
// ----------------------------------------------------------------------------
module trc_rotor (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  trc_pkg::tbl_wr_t wr_i,
  input  trc_pkg::letter_t pos_i,
  input  trc_pkg::letter_t fwd_i,
  output trc_pkg::letter_t fwd_o,
  input  trc_pkg::letter_t bwd_i,
  output trc_pkg::letter_t bwd_o
);

  trc_pkg::letter_t fwd_map_q [trc_pkg::ALPHA_N];
  trc_pkg::letter_t inv_map_q [trc_pkg::ALPHA_N];

  // A wiring load sets fwd[idx] = val and inv[val] = idx.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < trc_pkg::ALPHA_N; i++) begin
        fwd_map_q[i] <= trc_pkg::LETTER_W'(i);
        inv_map_q[i] <= trc_pkg::LETTER_W'(i);
      end
    end else if (wr_i.en) begin
      for (int i = 0; i < trc_pkg::ALPHA_N; i++) begin
        if (wr_i.idx == trc_pkg::LETTER_W'(i)) begin
          fwd_map_q[i] <= wr_i.val;
        end
        if (wr_i.val == trc_pkg::LETTER_W'(i)) begin
          inv_map_q[i] <= wr_i.idx;
        end
      end
    end
  end

  // Inbound: subtract the position, then look up the wiring.
  assign fwd_o = fwd_map_q[trc_pkg::sub_mod(fwd_i, pos_i)];

  // Return: look up the inverse wiring, then add the position back.
  assign bwd_o = trc_pkg::add_mod(inv_map_q[bwd_i], pos_i);

endmodule

[sv/trc_odometer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trc_odometer
// Rotor position counters. Right steps on every cipher transaction and
// carries into middle, which carries into left; each wraps at the alphabet
// size.
// ----------------------------------------------------------------------------
module trc_odometer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  trc_pkg::odo_ctrl_t ctrl_i,
  output trc_pkg::letter_t   pos_right_o,
  output trc_pkg::letter_t   pos_middle_o,
  output trc_pkg::letter_t   pos_left_o
);

  trc_pkg::letter_t pos_right_q, pos_right_d;
  trc_pkg::letter_t pos_middle_q, pos_middle_d;
  trc_pkg::letter_t pos_left_q, pos_left_d;
  logic             carry_right, carry_middle;

  // Carries ripple only when the lower rotors sit at their last position.
  assign carry_right  = (pos_right_q == trc_pkg::ALPHA_LAST);
  assign carry_middle = carry_right && (pos_middle_q == trc_pkg::ALPHA_LAST);

  always_comb begin
    pos_right_d  = pos_right_q;
    pos_middle_d = pos_middle_q;
    pos_left_d   = pos_left_q;
    if (ctrl_i.step) begin
      pos_right_d = carry_right ? '0 : pos_right_q + 1'b1;
      if (carry_right) begin
        pos_middle_d = (pos_middle_q == trc_pkg::ALPHA_LAST) ? '0 : pos_middle_q + 1'b1;
      end
      if (carry_middle) begin
        pos_left_d = (pos_left_q == trc_pkg::ALPHA_LAST) ? '0 : pos_left_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_right_q  <= '0;
      pos_middle_q <= '0;
      pos_left_q   <= '0;
    end else begin
      pos_right_q  <= pos_right_d;
      pos_middle_q <= pos_middle_d;
      pos_left_q   <= pos_left_d;
    end
  end

  assign pos_right_o  = pos_right_q;
  assign pos_middle_o = pos_middle_q;
  assign pos_left_o   = pos_left_q;

endmodule

[sv/three_rotor_reflector_cipher_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_rotor_reflector_cipher_top
// Self-inverse three-rotor cipher with plugboard and mirror reflector.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle on the input channel while a
// cipher result is not held on a full output register. A transaction is
// registered on acceptance and then, once it moves on, either updates a
// plugboard pair or one rotor wiring entry (no result), or passes a byte
// through plugboard, three rotors, reflector, the rotors in reverse and the
// plugboard again into the output register, from which a cipher result is
// presented on the output. A single lookup chain lies between the input and
// output registers.
// Table loads and position steps take effect in transaction order, so each
// byte sees every earlier load. Bytes outside 'A'..'Z' pass unchanged but
// still step the rotors. While a result waits for the consumer, table loads
// still go on and one cipher transaction can wait in the input register.
// ----------------------------------------------------------------------------
module three_rotor_reflector_cipher_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [0:0] op_i,
  input  logic [1:0] table_sel_i,
  input  logic [4:0] entry_index_i,
  input  logic [4:0] entry_value_i,
  input  logic [7:0] char_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] char_out_o
);

  // Input register.
  logic                                  in_valid_q;
  trc_pkg::op_e                          op_q;
  trc_pkg::table_sel_e                   sel_q;
  logic [trc_pkg::FIELD_W-1:0]           idx_q;
  logic [trc_pkg::FIELD_W-1:0]           val_q;
  trc_pkg::char_t                        char_q;

  // Output register.
  logic                                  out_valid_q, out_valid_d;
  trc_pkg::char_t                        char_out_q;

  logic                                  advance;
  logic                                  is_cipher;
  logic                                  load_ok;
  logic                                  is_letter;
  logic [trc_pkg::CHAR_W-1:0]            char_off;
  trc_pkg::letter_t                      letter_in;
  trc_pkg::tbl_wr_t                      wr_cmd;
  trc_pkg::tbl_wr_t                      wr_plug, wr_left, wr_middle, wr_right;
  trc_pkg::odo_ctrl_t                    odo_ctrl;
  trc_pkg::letter_t                      pos_right, pos_middle, pos_left;
  trc_pkg::letter_t                      x_plug, x_right, x_middle, x_left, x_refl;
  trc_pkg::letter_t                      y_left, y_middle, y_right, y_plug;
  trc_pkg::char_t                        char_res;

  // Handshake: the registered transaction moves on unless its result would
  // land on a full output register that is not being drained.
  assign is_cipher  = (op_q == trc_pkg::OP_CIPHER);
  assign advance    = in_valid_q && (!is_cipher || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      op_q   <= trc_pkg::op_e'(op_i);
      sel_q  <= trc_pkg::table_sel_e'(table_sel_i);
      idx_q  <= entry_index_i;
      val_q  <= entry_value_i;
      char_q <= char_in_i;
    end
  end

  // Load decode: out-of-range entries are dropped.
  assign load_ok = ({1'b0, idx_q} < trc_pkg::FIELD_LIM) &&
                   ({1'b0, val_q} < trc_pkg::FIELD_LIM);

  assign wr_cmd.en  = advance && !is_cipher && load_ok;
  assign wr_cmd.idx = trc_pkg::LETTER_W'(idx_q);
  assign wr_cmd.val = trc_pkg::LETTER_W'(val_q);

  always_comb begin
    wr_plug      = wr_cmd;
    wr_left      = wr_cmd;
    wr_middle    = wr_cmd;
    wr_right     = wr_cmd;
    wr_plug.en   = 1'b0;
    wr_left.en   = 1'b0;
    wr_middle.en = 1'b0;
    wr_right.en  = 1'b0;
    unique case (sel_q)
      trc_pkg::SEL_PLUG:   wr_plug.en   = wr_cmd.en;
      trc_pkg::SEL_LEFT:   wr_left.en   = wr_cmd.en;
      trc_pkg::SEL_MIDDLE: wr_middle.en = wr_cmd.en;
      trc_pkg::SEL_RIGHT:  wr_right.en  = wr_cmd.en;
      default:             wr_plug.en   = 1'b0;
    endcase
  end

  // Every cipher transaction steps the rotors, letter or not.
  assign odo_ctrl.step = advance && is_cipher;

  // Letter detection and conversion to an alphabet index.
  assign char_off  = char_q - trc_pkg::LETTER_BASE;
  assign is_letter = (char_q >= trc_pkg::LETTER_BASE) &&
                     ({1'b0, char_off} < trc_pkg::CHAR_LIM);
  assign letter_in = trc_pkg::LETTER_W'(char_off);

  trc_odometer u_odometer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (odo_ctrl),
    .pos_right_o  (pos_right),
    .pos_middle_o (pos_middle),
    .pos_left_o   (pos_left)
  );

  trc_plugboard u_plugboard (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr_plug),
    .entry_i (letter_in),
    .entry_o (x_plug),
    .exit_i  (y_right),
    .exit_o  (y_plug)
  );

  trc_rotor u_rotor_right (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (wr_right),
    .pos_i  (pos_right),
    .fwd_i  (x_plug),
    .fwd_o  (x_right),
    .bwd_i  (y_middle),
    .bwd_o  (y_right)
  );

  trc_rotor u_rotor_middle (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (wr_middle),
    .pos_i  (pos_middle),
    .fwd_i  (x_right),
    .fwd_o  (x_middle),
    .bwd_i  (y_left),
    .bwd_o  (y_middle)
  );

  trc_rotor u_rotor_left (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (wr_left),
    .pos_i  (pos_left),
    .fwd_i  (x_middle),
    .fwd_o  (x_left),
    .bwd_i  (x_refl),
    .bwd_o  (y_left)
  );

  // Mirror reflector.
  assign x_refl = trc_pkg::ALPHA_LAST - x_left;

  // Back to a byte; non-letters pass through.
  assign char_res = is_letter ? (trc_pkg::CHAR_W'(y_plug) + trc_pkg::LETTER_BASE) : char_q;

  // Output register control.
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && is_cipher) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && is_cipher) begin
      char_out_q <= char_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign char_out_o  = char_out_q;

endmodule
